// ===== design/tvpd_pkg.sv =====
`default_nettype none
package tvpd_pkg;

  localparam int TPP_W   = 10;
  localparam int POS_W   = 7;
  localparam int TGT_W   = 8;
  localparam int MC_W    = 18;
  localparam int MAG_W   = MC_W - 1;
  localparam int DIR_W   = 2;

  localparam logic [TPP_W-1:0] TPP_RESET = 10'd100;

  localparam logic [POS_W-1:0]        FULL_OPEN   = 7'd100;
  localparam logic signed [TGT_W-1:0] OVER_OPEN   = 8'sd103;
  localparam logic signed [TGT_W-1:0] OVER_CLOSED = -8'sd3;

  localparam logic [DIR_W-1:0] DIR_IDLE  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_OPEN  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_CLOSE = 2'd2;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  typedef struct packed {
    logic take_target;
    logic set_dir;
    logic mod_start;
    logic step;
    logic chk;
    logic load;
    logic count;
    logic out_load;
  } tvpd_cmd_t;

  typedef struct packed {
    logic mc_zero;
    logic tpp_zero;
    logic mod_done;
    logic can_step;
    logic differ;
    logic out_full;
  } tvpd_stat_t;

endpackage
`default_nettype wire

// ===== design/tvpd_mod.sv =====
`default_nettype none
module tvpd_mod (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [tvpd_pkg::MAG_W-1:0]  dividend,
  input  wire logic [tvpd_pkg::TPP_W-1:0]  divisor,
  output logic                             done,
  output logic                             zero
);
  import tvpd_pkg::*;

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [MAG_W-1:0] dvd_r, dvd_nxt;
  logic [TPP_W-1:0] rem_r, rem_nxt;
  logic [TPP_W:0]   sh;

  always_comb begin
    sh       = {rem_r, dvd_r[MAG_W-1]};
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      cnt_nxt  = CNT_W'(MAG_W);
      busy_nxt = 1'b1;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[MAG_W-2:0], 1'b0};
      if (sh >= {1'b0, divisor}) begin
        rem_nxt = TPP_W'(sh - {1'b0, divisor});
      end else begin
        rem_nxt = sh[TPP_W-1:0];
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign zero = (rem_r == '0);

endmodule
`default_nettype wire

// ===== design/tvpd_dp.sv =====
`default_nettype none
module tvpd_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tvpd_pkg::tvpd_cmd_t         cmd,
  output tvpd_pkg::tvpd_stat_t             stat,
  input  wire logic [tvpd_pkg::TPP_W-1:0]  tpp,
  input  wire logic [tvpd_pkg::POS_W-1:0]  new_target,
  input  wire logic                        out_tready,
  output logic                             out_tvalid,
  output logic                             out_open,
  output logic                             out_close,
  output logic [tvpd_pkg::POS_W-1:0]       out_pos,
  output logic [tvpd_pkg::TGT_W-1:0]       out_tgt
);
  import tvpd_pkg::*;

  logic [POS_W-1:0]        pend_r;
  logic signed [TGT_W-1:0] tif_r;
  logic [POS_W-1:0]        pos_r;
  logic signed [MC_W-1:0]  mc_r;
  logic [DIR_W-1:0]        dir_r;
  logic signed [TGT_W-1:0] diff_r;

  logic                    ov_r;
  logic                    oo_r, oc_r;
  logic [POS_W-1:0]        op_r;
  logic [TGT_W-1:0]        ot_r;

  logic [POS_W-1:0]        sat_tgt;
  logic signed [TGT_W-1:0] new_tif;
  logic signed [TGT_W:0]   diff_w;
  logic signed [MC_W:0]    prod;
  logic signed [MC_W-1:0]  mc_neg;
  logic [MAG_W-1:0]        mag;
  logic                    mod_done, mod_zero;
  logic                    bound_ok;

  assign sat_tgt = (new_target > FULL_OPEN) ? FULL_OPEN : new_target;

  always_comb begin
    new_tif = TGT_W'(signed'({1'b0, pend_r}));
    if (pend_r == FULL_OPEN && pos_r < FULL_OPEN) begin
      new_tif = OVER_OPEN;
    end else if (pend_r == '0 && pos_r != '0) begin
      new_tif = OVER_CLOSED;
    end
  end

  assign diff_w = (TGT_W+1)'(new_tif) - (TGT_W+1)'(signed'({1'b0, pos_r}));
  assign prod   = diff_r * signed'({1'b0, tpp});
  assign mc_neg = -mc_r;
  assign mag    = mc_r[MC_W-1] ? mc_neg[MAG_W-1:0] : mc_r[MAG_W-1:0];

  assign bound_ok = (dir_r == DIR_OPEN) ? (pos_r < FULL_OPEN) : (pos_r != '0);

  tvpd_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (mag),
    .divisor  (tpp),
    .done     (mod_done),
    .zero     (mod_zero)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      tif_r  <= '0;
      pos_r  <= '0;
      mc_r   <= '0;
      dir_r  <= DIR_IDLE;
      ov_r   <= 1'b0;
    end else begin
      if (cmd.take_target) begin
        pend_r <= sat_tgt;
      end
      if (cmd.set_dir) begin
        if (mc_r == '0) begin
          dir_r <= DIR_IDLE;
        end else if (mc_r[MC_W-1]) begin
          dir_r <= DIR_CLOSE;
        end else begin
          dir_r <= DIR_OPEN;
        end
      end
      if (cmd.step) begin
        if (dir_r == DIR_OPEN) begin
          pos_r <= pos_r + 1'b1;
        end else begin
          pos_r <= pos_r - 1'b1;
        end
      end
      if (cmd.chk) begin
        tif_r <= new_tif;
      end
      if (cmd.load) begin
        mc_r <= prod[MC_W-1:0];
      end else if (cmd.count) begin
        if (dir_r == DIR_OPEN) begin
          mc_r <= mc_r - 1'b1;
        end else begin
          mc_r <= mc_r + 1'b1;
        end
      end
      if (cmd.out_load) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
    if (cmd.chk) begin
      diff_r <= diff_w[TGT_W-1:0];
    end
    if (cmd.out_load) begin
      oo_r <= (dir_r == DIR_OPEN);
      oc_r <= (dir_r == DIR_CLOSE);
      op_r <= pos_r;
      ot_r <= tif_r;
    end
  end

  always_comb begin
    stat.mc_zero  = (mc_r == '0);
    stat.tpp_zero = (tpp == '0);
    stat.mod_done = mod_done;
    stat.can_step = (tpp != '0) && mod_zero && bound_ok;
    stat.differ   = (TGT_W'(signed'({1'b0, pend_r})) != tif_r);
    stat.out_full = ov_r && !out_tready;
  end

  assign out_tvalid = ov_r;
  assign out_open   = oo_r;
  assign out_close  = oc_r;
  assign out_pos    = op_r;
  assign out_tgt    = ot_r;

endmodule
`default_nettype wire

// ===== design/tvpd_ctrl.sv =====
`default_nettype none
module tvpd_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_op,
  output logic                       in_tready,
  input  wire tvpd_pkg::tvpd_stat_t  stat,
  output tvpd_pkg::tvpd_cmd_t        cmd
);
  import tvpd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_STEP  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_COUNT = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       cnt_r, cnt_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_op == OP_SET) begin
            cmd.take_target = 1'b1;
            state_nxt       = S_DONE;
          end else begin
            cmd.set_dir = 1'b1;
            if (stat.mc_zero) begin
              cnt_nxt   = 1'b0;
              state_nxt = S_CHECK;
            end else begin
              cnt_nxt = 1'b1;
              if (stat.tpp_zero) begin
                state_nxt = S_STEP;
              end else begin
                cmd.mod_start = 1'b1;
                state_nxt     = S_MOD;
              end
            end
          end
        end
      end
      S_MOD: begin
        if (stat.mod_done) begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (stat.can_step) begin
          cmd.step  = 1'b1;
          state_nxt = S_CHECK;
        end else begin
          state_nxt = S_COUNT;
        end
      end
      S_CHECK: begin
        if (stat.differ) begin
          cmd.chk   = 1'b1;
          state_nxt = S_LOAD;
        end else if (cnt_r) begin
          state_nxt = S_COUNT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = cnt_r ? S_COUNT : S_DONE;
      end
      S_COUNT: begin
        cmd.count = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/timed_valve_position_drive_unit.sv =====
`default_nettype none
// Flow: a set-target item takes the new target, then loads its result. A tick item with the
// counter at zero checks the target and reloads the counter when the target changed. With the
// counter running, it skips the modulo unit when ticks_per_percent is zero, else it waits for
// the 17-step bit-serial modulo unit that tests the counter against ticks_per_percent.
// Throughput: one item at a time, the next taken once the result is loaded, also
// while that result still waits in the output register. Reset: synchronous, active low.
// It clears targets, position, counter and direction, and loads ticks_per_percent with 100.
module timed_valve_position_drive_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [6:0] new_target, [7] zero
  input  wire logic         in_tuser,   // [0] operation
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [23:0]       out_tdata,  // [0] open_drive, [1] close_drive, [8:2] position,
                                        // [16:9] active_target, [23:17] zero
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import tvpd_pkg::*;

  logic [TPP_W-1:0] tpp_r;
  tvpd_cmd_t        cmd;
  tvpd_stat_t       stat;
  logic             o_open, o_close;
  logic [POS_W-1:0] o_pos;
  logic [TGT_W-1:0] o_tgt;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpp_r <= TPP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      tpp_r <= pwdata[TPP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? {{(32-TPP_W){1'b0}}, tpp_r} : 32'd0;

  tvpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tvpd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .tpp        (tpp_r),
    .new_target (in_tdata[POS_W-1:0]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_open   (o_open),
    .out_close  (o_close),
    .out_pos    (o_pos),
    .out_tgt    (o_tgt)
  );

  assign out_tdata = {7'd0, o_tgt, o_pos, o_close, o_open};

endmodule
`default_nettype wire
